>>> hw/rtl/tccjc_pkg.sv
// Package for the thermocouple cold-junction compensation block.
// Holds table geometry, datapath widths, field codes and the table entry type.
// No dependencies.
package tccjc_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Field widths fixed by the interface.
    localparam int CNT_W   = 9;
    localparam int TEMP_W  = 16;
    localparam int VOLT_W  = 18;
    localparam int STAT_W  = 2;

    // Stream payload widths (packed fields rounded up to whole bytes).
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 24;

    // Interpolation datapath widths.
    localparam int XW      = VOLT_W;          // search key, holds either column
    localparam int DIFF_W  = 20;              // differences of two keys or values
    localparam int PROD_W  = 2 * DIFF_W;      // signed product
    localparam int QMAG_W  = PROD_W - 1;      // magnitude of the product
    localparam int DEN_W   = DIFF_W;          // magnitude of the divisor
    localparam int Q_W     = QMAG_W + 1;      // signed quotient
    localparam int RES_W   = Q_W + 1;         // base value plus quotient
    localparam int ACC_W   = RES_W + 1;       // interpolated voltage plus measurement
    localparam int DCNT_W  = $clog2(QMAG_W);

    // Input selector codes.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_COLD_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_VOLT_RANGE = 2'd2;

    // One table row: voltage in microvolts, temperature in 1/16 degC.
    typedef struct packed {
        logic signed [VOLT_W-1:0] volt;
        logic signed [TEMP_W-1:0] temp;
    } entry_t;

endpackage

>>> hw/rtl/thermocouple_cjc_table_interp.sv
// Top level of the thermocouple cold-junction compensation block.
// Table memory, sequencer, shared multiplier and serial divider in one module.
// Depends on tccjc_pkg.

// A load transfer (tuser = 0) writes one table row when it is accepted. A convert
// transfer (tuser = 1) checks the cold-junction temperature against the first and
// last rows, finds the segment that holds it, interpolates it to a voltage, adds
// the measured voltage, checks that sum against the voltage column and finally
// interpolates back to the hot-junction temperature. All work is done by one
// sequencer around a single table read port, one multiplier and a one-bit-per-
// cycle restoring divider. The two searches read one table row per cycle, from
// the second row upward, until they reach the row that bounds the key. A flat
// segment skips its division, and a range failure ends the convert early. The
// block accepts nothing while a convert is in progress or its result waits on
// the output. The result transfer carries the status code and the temperature,
// which is forced to zero whenever the status is not OK. The row count register
// is clamped to 2..TABLE_DEPTH when a convert starts, and it is only to be
// written while the block is idle.
module thermocouple_cjc_table_interp (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: number of rows in use.
    input  logic                          cfg_we,
    input  logic [tccjc_pkg::CNT_W-1:0]   cfg_wdata,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, lowest bit up: entry_index[7:0], entry_temp[15:0],
    // entry_voltage[17:0], junction_voltage[17:0], cold_junction_temp[15:0], zeros
    input  logic [tccjc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: mode (0 load, 1 convert)
    input  logic                          s_axis_tuser,
    // Output stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata, lowest bit up: status[1:0], hot_junction_temp[15:0], zeros
    output logic [tccjc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    import tccjc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_SEARCH,
        ST_RD_LOW,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_OUT
    } state_t;

    // Clamp the row count and turn it into the index of the last row in use.
    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] cnt);
        int unsigned n;
        n = cnt;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return IDX_W'(n - 1);
    endfunction

    // Input payload fields.
    logic [7:0]               in_entry_index;
    logic signed [TEMP_W-1:0] in_entry_temp;
    logic signed [VOLT_W-1:0] in_entry_volt;
    logic signed [VOLT_W-1:0] in_junction_volt;
    logic signed [TEMP_W-1:0] in_cold_temp;
    logic                     in_accept;

    assign in_entry_index   = s_axis_tdata[7:0];
    assign in_entry_temp    = s_axis_tdata[23:8];
    assign in_entry_volt    = s_axis_tdata[41:24];
    assign in_junction_volt = s_axis_tdata[59:42];
    assign in_cold_temp     = s_axis_tdata[75:60];
    assign in_accept        = s_axis_tvalid & s_axis_tready;

    // Registers.
    state_t                   state_reg;
    logic [CNT_W-1:0]         entries_in_use_reg;
    logic [IDX_W-1:0]         last_idx_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     pass_reg;        // 0: temperature to voltage, 1: back
    logic signed [XW-1:0]     x_reg;
    logic signed [VOLT_W-1:0] vj_reg;
    logic signed [TEMP_W-1:0] t0_reg;
    logic signed [VOLT_W-1:0] v0_reg;
    logic signed [VOLT_W-1:0] vn_reg;
    logic signed [XW-1:0]     x1_reg;
    logic signed [XW-1:0]     y1_reg;
    logic signed [XW-1:0]     y0_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] den_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [QMAG_W-1:0]        num_reg;         // dividend, then quotient
    logic [DEN_W-1:0]         dmag_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic                     m_tvalid_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [TEMP_W-1:0] hot_reg;

    // Table memory with one write port and one registered read port.
    entry_t                   table_mem [TABLE_DEPTH];
    entry_t                   rd_q;
    logic [IDX_W-1:0]         rd_addr;
    logic                     load_we;
    logic [IDX_W-1:0]         load_addr;
    entry_t                   load_entry;

    assign load_we = in_accept && (s_axis_tuser == MODE_LOAD)
                     && (32'(in_entry_index) < TABLE_DEPTH);
    assign load_addr = IDX_W'(in_entry_index);
    assign load_entry.volt = in_entry_volt;
    assign load_entry.temp = in_entry_temp;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            table_mem[load_addr] <= load_entry;
        end
        rd_q <= table_mem[rd_addr];
    end

    // Search key and paired value of the row just read, selected by the pass.
    logic signed [XW-1:0] key;
    logic signed [XW-1:0] other;
    logic                 found;

    assign key   = pass_reg ? rd_q.volt : XW'(rd_q.temp);
    assign other = pass_reg ? XW'(rd_q.temp) : rd_q.volt;
    assign found = (idx_reg == last_idx_reg) || (x_reg <= key);

    // The address issued in one state is read in the state that follows.
    always_comb
    begin
        case (state_reg)
            ST_RD_FIRST: rd_addr = last_idx_reg;
            ST_RD_LAST:  rd_addr = IDX_W'(1);
            ST_SEARCH:   rd_addr = found ? (idx_reg - IDX_W'(1)) : (idx_reg + IDX_W'(1));
            ST_DIV_DONE: rd_addr = IDX_W'(1);
            default:     rd_addr = '0;
        endcase
    end

    // Divider step and final combination of the quotient.
    logic [DEN_W:0]           rem_sh;
    logic                     rem_ge;
    logic signed [Q_W-1:0]    q_val;
    logic signed [RES_W-1:0]  res_val;
    logic signed [ACC_W-1:0]  total_val;
    logic                     volt_out_of_range;
    logic signed [TEMP_W-1:0] hot_sat;
    logic signed [PROD_W-1:0] prod_abs;
    logic signed [DIFF_W-1:0] den_abs;

    assign rem_sh  = {rem_reg, num_reg[QMAG_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, dmag_reg};
    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign den_abs  = den_reg[DIFF_W-1] ? -den_reg : den_reg;

    always_comb
    begin
        q_val     = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
        res_val   = RES_W'(y0_reg) + RES_W'(q_val);
        total_val = ACC_W'(res_val) + ACC_W'(vj_reg);
        volt_out_of_range = (total_val < ACC_W'(v0_reg)) || (total_val > ACC_W'(vn_reg));
        if (res_val > RES_W'(32767))
        begin
            hot_sat = 16'sh7FFF;
        end
        else if (res_val < -RES_W'(32768))
        begin
            hot_sat = -16'sh8000;
        end
        else
        begin
            hot_sat = res_val[TEMP_W-1:0];
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            entries_in_use_reg <= CNT_W'(2);
            last_idx_reg       <= '0;
            idx_reg            <= '0;
            pass_reg           <= 1'b0;
            x_reg              <= '0;
            vj_reg             <= '0;
            t0_reg             <= '0;
            v0_reg             <= '0;
            vn_reg             <= '0;
            x1_reg             <= '0;
            y1_reg             <= '0;
            y0_reg             <= '0;
            dx_reg             <= '0;
            dy_reg             <= '0;
            den_reg            <= '0;
            prod_reg           <= '0;
            num_reg            <= '0;
            dmag_reg           <= '0;
            rem_reg            <= '0;
            neg_reg            <= 1'b0;
            dcnt_reg           <= '0;
            m_tvalid_reg       <= 1'b0;
            status_reg         <= STATUS_OK;
            hot_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_in_use_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (s_axis_tuser == MODE_CONVERT))
                    begin
                        last_idx_reg <= last_index(entries_in_use_reg);
                        x_reg        <= XW'(in_cold_temp);
                        vj_reg       <= in_junction_volt;
                        pass_reg     <= 1'b0;
                        state_reg    <= ST_RD_FIRST;
                    end
                end
                ST_RD_FIRST:
                begin
                    t0_reg    <= rd_q.temp;
                    v0_reg    <= rd_q.volt;
                    state_reg <= ST_RD_LAST;
                end
                ST_RD_LAST:
                begin
                    vn_reg <= rd_q.volt;
                    if ((x_reg < XW'(t0_reg)) || (x_reg > XW'(rd_q.temp)))
                    begin
                        status_reg   <= STATUS_COLD_RANGE;
                        hot_reg      <= '0;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= IDX_W'(1);
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (found)
                    begin
                        x1_reg    <= key;
                        y1_reg    <= other;
                        state_reg <= ST_RD_LOW;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_RD_LOW:
                begin
                    den_reg   <= DIFF_W'(x1_reg) - DIFF_W'(key);
                    dx_reg    <= DIFF_W'(x_reg) - DIFF_W'(key);
                    dy_reg    <= DIFF_W'(y1_reg) - DIFF_W'(other);
                    y0_reg    <= other;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= dy_reg * dx_reg;
                    state_reg <= ST_DIV_INIT;
                end
                ST_DIV_INIT:
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    if (den_reg == '0)
                    begin
                        // Flat segment: the result is the lower row's value.
                        num_reg   <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= ST_DIV_DONE;
                    end
                    else
                    begin
                        num_reg   <= prod_abs[QMAG_W-1:0];
                        dmag_reg  <= den_abs[DEN_W-1:0];
                        neg_reg   <= prod_reg[PROD_W-1] ^ den_reg[DIFF_W-1];
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_ge ? DEN_W'(rem_sh - {1'b0, dmag_reg}) : rem_sh[DEN_W-1:0];
                    num_reg  <= {num_reg[QMAG_W-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(QMAG_W - 1))
                    begin
                        state_reg <= ST_DIV_DONE;
                    end
                end
                ST_DIV_DONE:
                begin
                    if (!pass_reg)
                    begin
                        if (volt_out_of_range)
                        begin
                            status_reg   <= STATUS_VOLT_RANGE;
                            hot_reg      <= '0;
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= ST_OUT;
                        end
                        else
                        begin
                            // The sum lies inside the voltage column, so it fits a key.
                            x_reg     <= total_val[XW-1:0];
                            pass_reg  <= 1'b1;
                            idx_reg   <= IDX_W'(1);
                            state_reg <= ST_SEARCH;
                        end
                    end
                    else
                    begin
                        status_reg   <= STATUS_OK;
                        hot_reg      <= hot_sat;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - STAT_W - TEMP_W){1'b0}}, hot_reg, status_reg};

`ifndef NO_ASSERTIONS
    // Input and output sides are never open together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // A convert transfer always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == MODE_CONVERT)) |=> (state_reg == ST_RD_FIRST))
        else $error("convert transfer did not start the sequencer");

    // A failed range check never carries a temperature.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (status_reg != STATUS_OK)) |-> (hot_reg == '0))
        else $error("error result with non-zero temperature");

    // The segment search stays inside the rows in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ((idx_reg != '0) && (idx_reg <= last_idx_reg)))
        else $error("segment search left the table");

    // The divider never runs past its last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dcnt_reg <= DCNT_W'(QMAG_W - 1)))
        else $error("divider step count overran");
`endif

endmodule
